### design/aes_cbc_mac_padded_assert.svh
// assertion macros shared by the checker of the cbc-mac block
// no dependencies
`ifndef AES_CBC_MAC_PADDED_ASSERT_SVH
`define AES_CBC_MAC_PADDED_ASSERT_SVH
`define ACM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ACM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/acm_pkg.sv
// package of the aes-128 cbc-mac block: types, constants, aes functions
// no dependencies
package acm_pkg;
    localparam int unsigned BlockBytes = 16;
    localparam int unsigned Rounds     = 10;
    localparam int unsigned QueueDepth = 2;
    localparam logic [127:0] ResetKey = 128'h000102030405060708090a0b0c0d0e0f;

    typedef enum logic [0:0] {
        CFG_KEY_UPPER = 1'b0,
        CFG_KEY_LOWER = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [63:0] tag_upper;
        logic [63:0] tag_lower;
    } t_out;

    // one queue entry: a full block to absorb, and whether it ends the message
    typedef struct packed {
        logic [127:0] blk;
        logic         last;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYX,
        ST_ROUND,
        ST_DONE
    } t_state;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits 127-8i .. 120-8i
    function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

    // next round key from the current one
    function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // one cipher round (subbytes, shiftrows, optional mixcolumns, addroundkey)
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = sbox(byte_of(s, i + 4 * ((c + i) % 4)));
            end
        end
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
                t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = t[i];
        end
        return r ^ k;
    endfunction
endpackage

### design/acm_front.sv
// front end: packs bytes into blocks and applies pkcs#7 padding
// depends on acm_pkg
module acm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  acm_pkg::t_in   i_data,
    output logic           o_job_valid,
    input  logic           i_job_stall,
    output acm_pkg::t_job  o_job
);
    logic [127:0] r_buf, n_buf;
    logic [3:0]   r_fill, n_fill;
    logic         r_pad_pend, n_pad_pend;
    logic         r_jv, n_jv;
    acm_pkg::t_job r_job, n_job;
    logic         take;
    logic [7:0]   pad;
    logic         slot_free;

    assign slot_free   = !r_jv || !i_job_stall;
    // while a whole padding block still has to go out, no new byte enters
    assign o_stall     = !slot_free || r_pad_pend;
    assign take        = i_valid && !o_stall;
    assign o_job_valid = r_jv;
    assign o_job       = r_job;

    always_comb begin
        n_buf      = r_buf;
        n_fill     = r_fill;
        n_pad_pend = r_pad_pend;
        n_jv       = r_jv && i_job_stall;
        n_job      = r_job;
        pad        = 8'(5'd16 - {1'b0, r_fill} - 5'd1);
        if (r_pad_pend && slot_free) begin
            n_jv       = 1'b1;
            n_job.blk  = {16{8'h10}};
            n_job.last = 1'b1;
            n_pad_pend = 1'b0;
        end else if (take) begin
            n_buf[127 - 8 * r_fill -: 8] = i_data.data_byte;
            n_fill = r_fill + 4'd1;
            if (r_fill == 4'd15) begin
                n_jv       = 1'b1;
                n_job.blk  = n_buf;
                n_job.last = 1'b0;
                n_pad_pend = i_data.is_last;
                n_fill     = 4'd0;
            end else if (i_data.is_last) begin
                for (int i = 0; i < 16; i++) begin
                    if (4'(i) > r_fill) begin
                        n_buf[127 - 8 * i -: 8] = pad;
                    end
                end
                n_jv       = 1'b1;
                n_job.blk  = n_buf;
                n_job.last = 1'b1;
                n_fill     = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_job <= n_job;
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_pad_pend <= 1'b0;
            r_jv       <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_pad_pend <= n_pad_pend;
            r_jv       <= n_jv;
        end
    end
endmodule

### design/acm_queue.sv
// short fifo of blocks between front end and cipher
// depends on acm_pkg
module acm_queue #(
    parameter int unsigned Depth = acm_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  acm_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_stall,
    output acm_pkg::t_job o_job
);
    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
    acm_pkg::t_job r_mem [Depth];
    logic [Aw-1:0] r_wp, r_rp;
    logic [Aw:0]   r_cnt;
    logic          push, pop;

    assign o_stall = (r_cnt == (Aw + 1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Aw + 1)'(push) - (Aw + 1)'(pop);
        end
    end
endmodule

### design/acm_core.sv
// back end: iterative aes-128 with on-the-fly key schedule, cbc chaining, tag register
// depends on acm_pkg
module acm_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [127:0]  i_key,
    input  logic          i_valid,
    output logic          o_stall,
    input  acm_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_stall,
    output acm_pkg::t_out o_data
);
    acm_pkg::t_state r_st, n_st;
    logic [127:0] r_chain, r_state, r_rkey;
    logic [3:0]   r_rnd;
    logic [7:0]   r_rc;
    logic         r_last;
    logic         r_ov;
    acm_pkg::t_out r_out;
    logic         take, out_free, fin, mix;
    logic [127:0] nk, ns;

    assign out_free = !r_ov || !i_stall;
    assign take     = (r_st == acm_pkg::ST_IDLE) && i_valid;
    assign o_stall  = (r_st != acm_pkg::ST_IDLE);
    assign o_valid  = r_ov;
    assign o_data   = r_out;
    assign nk       = acm_pkg::next_rkey(r_rkey, r_rc);
    assign mix      = (r_rnd != 4'(acm_pkg::Rounds));
    assign ns       = acm_pkg::aes_round(r_state, nk, mix);
    assign fin      = (r_st == acm_pkg::ST_DONE) && (!r_last || out_free);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            acm_pkg::ST_IDLE:  if (i_valid) n_st = acm_pkg::ST_ROUND;
            acm_pkg::ST_KEYX:  n_st = acm_pkg::ST_ROUND;
            acm_pkg::ST_ROUND: if (r_rnd == 4'(acm_pkg::Rounds)) n_st = acm_pkg::ST_DONE;
            acm_pkg::ST_DONE:  if (fin) n_st = acm_pkg::ST_IDLE;
            default:           n_st = acm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_state <= (r_chain ^ i_job.blk) ^ i_key;
            r_rkey  <= i_key;
            r_rc    <= 8'h01;
            r_rnd   <= 4'd1;
            r_last  <= i_job.last;
        end else if (r_st == acm_pkg::ST_ROUND) begin
            r_state <= ns;
            r_rkey  <= nk;
            r_rc    <= acm_pkg::xtime(r_rc);
            r_rnd   <= r_rnd + 4'd1;
        end
        if (fin && r_last) begin
            r_out <= {r_state[127:64], r_state[63:0]};
        end
        if (!i_rst_n) begin
            r_st    <= acm_pkg::ST_IDLE;
            r_chain <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_st <= n_st;
            if (fin) begin
                r_chain <= r_last ? '0 : r_state;
            end
            if (fin && r_last) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule

### design/aes_cbc_mac_padded.sv
// top level of the aes-128 cbc-mac with pkcs#7 padding
// depends on acm_pkg, acm_front, acm_queue, acm_core
//
//  channel | signals                          | moves
//  in      | i_valid, o_stall, i_data         | one message byte per request
//  out     | o_valid, i_stall, o_data         | one 128-bit tag per message
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data  | key halves
//
// a byte request is taken while o_stall is low; a full block goes to the cipher,
// which works each block through a load, 10 rounds and a finish in one shared round unit
// a length that is a multiple of 16 adds one padding block
// reset is synchronous, active low; it clears the chain and fill count and sets the key to ResetKey
// a stalled tag holds the cipher on the last block; blocks keep entering the queue until it is full
module aes_cbc_mac_padded #(
    parameter int unsigned QueueDepth = acm_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  acm_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output acm_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);
    logic [127:0]  r_key;
    logic          f_jv, f_js, q_v, q_s;
    acm_pkg::t_job f_job, q_job;

    // key halves; an index out of range is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= acm_pkg::ResetKey;
        end else if (i_cfg_we && !i_cfg_idx[1]) begin
            unique case (acm_pkg::t_cfg_idx'(i_cfg_idx[0]))
                acm_pkg::CFG_KEY_UPPER: r_key[127:64] <= i_cfg_data;
                acm_pkg::CFG_KEY_LOWER: r_key[63:0]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_job_valid(f_jv), .i_job_stall(f_js), .o_job(f_job)
    );

    acm_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_jv), .o_stall(f_js), .i_job(f_job),
        .o_valid(q_v), .i_stall(q_s), .o_job(q_job)
    );

    acm_core u_core (
        .i_clk, .i_rst_n, .i_key(r_key), .i_valid(q_v), .o_stall(q_s), .i_job(q_job),
        .o_valid, .i_stall, .o_data
    );
endmodule

### design/acm_checker.sv
// port checker for the cbc-mac top level, bound to it
// depends on acm_pkg and aes_cbc_mac_padded_assert.svh
`include "aes_cbc_mac_padded_assert.svh"
module acm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input acm_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input acm_pkg::t_out o_data
);
    // a stalled tag holds
    `ACM_ASSERT_NEXT(a_tag_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    // a tag shown is fully defined
    `ACM_ASSERT_IMPL(a_tag_known, i_clk, i_rst_n, o_valid, !$isunknown(o_data))
    // handshake outputs are defined once out of reset
    `ACM_ASSERT_IMPL(a_stall_known, i_clk, i_rst_n, 1'b1, !$isunknown({o_stall, o_valid}))
    // an accepted byte request carries defined fields
    `ACM_ASSERT_IMPL(a_req_known, i_clk, i_rst_n, i_valid && !o_stall, !$isunknown(i_data))
endmodule

bind aes_cbc_mac_padded acm_checker u_acm_checker (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data, .o_valid, .i_stall, .o_data
);
